>>> hdl/gro_pkg.sv
package gro_pkg;

  // Field widths of the stream beats
  localparam int ModeBits  = 3;
  localparam int CoordBits = 6;
  localparam int SideBits  = 4;
  localparam int TagBits   = 8;
  localparam int FoundXBits = 7;
  localparam int ExtentBits = 7;

  // Operation codes carried in s_axis_tuser
  localparam logic [ModeBits-1:0] MODE_PLACE  = 3'd0;
  localparam logic [ModeBits-1:0] MODE_FIND   = 3'd1;
  localparam logic [ModeBits-1:0] MODE_REMOVE = 3'd2;
  localparam logic [ModeBits-1:0] MODE_MOVE   = 3'd3;
  localparam logic [ModeBits-1:0] MODE_GET    = 3'd4;
  localparam logic [ModeBits-1:0] MODE_CLEAR  = 3'd5;

  // Configuration register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

endpackage

>>> hdl/gro_grid_mem.sv
module gro_grid_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/grid_rectangle_occupancy_allocator.sv
// Rectangle allocator over a GRID_SIDE x GRID_SIDE occupancy grid held in one simple dual-port
// memory (one write and one registered read per cycle). Every beat on the slave side carries one
// operation in tuser and yields exactly one result beat. All cell work goes one cell per cycle
// through that memory, so an operation on a w x h rectangle walks up to w*h cells per pass:
// place runs a check pass, then a write pass, move adds a pass clearing the old spot, remove
// runs one clearing pass, get owner reads a single cell, and find free runs a check pass for each
// candidate position tried, first-fit with x as outer loop. Clear all sweeps the whole grid.
// After reset the same sweep runs before s_axis_tready first rises; configuration writes are
// taken throughout. One operation is in work at a time; a finished result waits in the output
// register while the next beat is taken.
module grid_rectangle_occupancy_allocator
  import gro_pkg::*;
#(
  parameter int GRID_SIDE     = 64,
  parameter int MAX_RECT_SIDE = 8,
  parameter int OWNER_BITS    = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[5:0], pos_y[11:6], rect_width[15:12], rect_height[19:16],
  // owner_tag[27:20], old_x[33:28], old_y[39:34]
  input  logic [39:0] s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]  s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // found_x[6:0], found_y[12:7], owner_read[20:13], zero[23:21]
  output logic [23:0] m_axis_tdata,
  // ok[0]
  output logic        m_axis_tuser
);

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_SIDE);
  localparam int CWB   = ($clog2(GRID_SIDE + 1) > ExtentBits) ? $clog2(GRID_SIDE + 1) : ExtentBits;
  localparam int CW    = CWB + 1;
  localparam int RW    = $clog2(MAX_RECT_SIDE + 1);

  localparam logic [3:0] ST_INIT    = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_START   = 4'd2;
  localparam logic [3:0] ST_CHECK   = 4'd3;
  localparam logic [3:0] ST_CHKLAST = 4'd4;
  localparam logic [3:0] ST_WRITE   = 4'd5;
  localparam logic [3:0] ST_ERASE   = 4'd6;
  localparam logic [3:0] ST_NEXT    = 4'd7;
  localparam logic [3:0] ST_GETRD   = 4'd8;
  localparam logic [3:0] ST_GETWAIT = 4'd9;
  localparam logic [3:0] ST_WIPE    = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  logic [3:0]            state_q, state_d;
  logic [ExtentBits-1:0] cols_cfg_q, rows_cfg_q;
  logic [ModeBits-1:0]   op_q, op_d;
  logic [CW-1:0]         base_x_q, base_x_d, base_y_q, base_y_d;
  logic [CW-1:0]         old_x_q, old_x_d, old_y_q, old_y_d;
  logic [RW-1:0]         w_q, w_d, h_q, h_d, i_q, i_d, j_q, j_d;
  logic [OWNER_BITS-1:0] id_q, id_d, rd_q, rd_d;
  logic                  pend_q, pend_d;
  logic                  ok_q, ok_d;
  logic [AW-1:0]         sweep_q, sweep_d;

  logic                  m_valid_q, m_valid_d;
  logic                  out_ok_q, out_ok_d;
  logic [6:0]            out_fx_q, out_fx_d;
  logic [5:0]            out_fy_q, out_fy_d;
  logic [7:0]            out_rd_q, out_rd_d;

  logic [CW-1:0]         cols_eff, rows_eff;
  logic [CW-1:0]         cell_x, cell_y;
  logic                  cell_in;
  logic [AW-1:0]         cell_addr;
  logic                  last_cell, empty_rect;
  logic                  chk_fail, chk_pass;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [OWNER_BITS-1:0] mem_wdata, mem_rdata;

  logic [SideBits-1:0]   in_w, in_h;
  logic [RW-1:0]         in_w_sat, in_h_sat;
  logic [15:0]           tag_ext, rd_ext;
  logic                  s_fire;

  gro_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (OWNER_BITS)
  ) u_grid_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  assign cols_eff = (cols_cfg_q > GRID_SIDE) ? CW'(GRID_SIDE) : CW'(cols_cfg_q);
  assign rows_eff = (rows_cfg_q > GRID_SIDE) ? CW'(GRID_SIDE) : CW'(rows_cfg_q);

  // Erase walks the old corner, every other pass walks the base corner
  assign cell_x = ((state_q == ST_ERASE) ? old_x_q : base_x_q) + CW'(i_q);
  assign cell_y = ((state_q == ST_ERASE) ? old_y_q : base_y_q) + CW'(j_q);
  assign cell_in = (cell_x < cols_eff) && (cell_y < rows_eff);
  assign cell_addr = AW'(cell_x[IW-1:0] * GRID_SIDE) + AW'(cell_y[IW-1:0]);

  assign last_cell  = (RW'(i_q + 1'b1) == w_q) && (RW'(j_q + 1'b1) == h_q);
  assign empty_rect = (w_q == '0) || (h_q == '0);

  assign in_w     = s_axis_tdata[15:12];
  assign in_h     = s_axis_tdata[19:16];
  assign in_w_sat = (in_w > MAX_RECT_SIDE) ? RW'(MAX_RECT_SIDE) : RW'(in_w);
  assign in_h_sat = (in_h > MAX_RECT_SIDE) ? RW'(MAX_RECT_SIDE) : RW'(in_h);
  assign tag_ext  = 16'(s_axis_tdata[27:20]);
  assign rd_ext   = 16'(rd_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    base_x_d  = base_x_q;
    base_y_d  = base_y_q;
    old_x_d   = old_x_q;
    old_y_d   = old_y_q;
    w_d       = w_q;
    h_d       = h_q;
    i_d       = i_q;
    j_d       = j_q;
    id_d      = id_q;
    rd_d      = rd_q;
    pend_d    = pend_q;
    ok_d      = ok_q;
    sweep_d   = sweep_q;
    chk_fail  = 1'b0;
    chk_pass  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = '0;
    mem_raddr = cell_addr;

    m_valid_d = m_valid_q;
    out_ok_d  = out_ok_q;
    out_fx_d  = out_fx_q;
    out_fy_d  = out_fy_q;
    out_rd_d  = out_rd_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT, ST_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == AW'(DEPTH - 1)) begin
          sweep_d = '0;
          ok_d    = 1'b1;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end

      ST_IDLE: begin
        if (s_fire) begin
          op_d     = s_axis_tuser;
          base_x_d = CW'(s_axis_tdata[5:0]);
          base_y_d = CW'(s_axis_tdata[11:6]);
          old_x_d  = CW'(s_axis_tdata[33:28]);
          old_y_d  = CW'(s_axis_tdata[39:34]);
          w_d      = in_w_sat;
          h_d      = in_h_sat;
          id_d     = tag_ext[OWNER_BITS-1:0];
          i_d      = '0;
          j_d      = '0;
          ok_d     = 1'b1;
          case (s_axis_tuser)
            MODE_PLACE, MODE_MOVE: state_d = ST_START;
            MODE_FIND:             state_d = ST_NEXT;
            MODE_REMOVE: begin
              state_d = ((in_w_sat == '0) || (in_h_sat == '0)) ? ST_DONE : ST_ERASE;
            end
            MODE_GET:              state_d = ST_GETRD;
            MODE_CLEAR:            state_d = ST_WIPE;
            default: begin
              ok_d    = 1'b0;
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // Next first-fit candidate: y inner, x outer
      ST_NEXT: begin
        if (base_x_q < cols_eff) begin
          if (base_y_q < rows_eff) begin
            state_d = ST_START;
          end else begin
            base_y_d = '0;
            base_x_d = base_x_q + 1'b1;
          end
        end else begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end
      end

      ST_START: begin
        i_d    = '0;
        j_d    = '0;
        pend_d = 1'b0;
        if (id_q == '0) begin
          chk_fail = 1'b1;
        end else if (empty_rect) begin
          chk_pass = 1'b1;
        end else begin
          state_d = ST_CHECK;
        end
      end

      // Issue one cell read per cycle, test the data of the cell before
      ST_CHECK: begin
        if ((pend_q && (mem_rdata != '0)) || !cell_in) begin
          chk_fail = 1'b1;
        end else begin
          pend_d = 1'b1;
          if (last_cell) begin
            state_d = ST_CHKLAST;
          end else if (RW'(j_q + 1'b1) == h_q) begin
            j_d = '0;
            i_d = i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end

      ST_CHKLAST: begin
        if (mem_rdata != '0) begin
          chk_fail = 1'b1;
        end else begin
          chk_pass = 1'b1;
        end
      end

      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = id_q;
        if (last_cell) begin
          i_d = '0;
          j_d = '0;
          if (op_q == MODE_MOVE) begin
            state_d = ST_ERASE;
          end else begin
            ok_d    = 1'b1;
            state_d = ST_DONE;
          end
        end else if (RW'(j_q + 1'b1) == h_q) begin
          j_d = '0;
          i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      // Clear cells inside the extents, skip cells outside them
      ST_ERASE: begin
        mem_we = cell_in;
        if (last_cell) begin
          ok_d    = 1'b1;
          state_d = ST_DONE;
        end else if (RW'(j_q + 1'b1) == h_q) begin
          j_d = '0;
          i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      ST_GETRD: begin
        if (cell_in) begin
          state_d = ST_GETWAIT;
        end else begin
          rd_d    = '0;
          state_d = ST_DONE;
        end
      end

      ST_GETWAIT: begin
        rd_d    = mem_rdata;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_ok_d  = ok_q;
          out_fx_d  = (op_q == MODE_FIND) ? base_x_q[6:0] : 7'd0;
          out_fy_d  = (op_q == MODE_FIND) ? base_y_q[5:0] : 6'd0;
          out_rd_d  = (op_q == MODE_GET) ? rd_ext[7:0] : 8'd0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (chk_fail) begin
      if (op_q == MODE_FIND) begin
        base_y_d = base_y_q + 1'b1;
        state_d  = ST_NEXT;
      end else begin
        ok_d    = 1'b0;
        state_d = ST_DONE;
      end
    end

    if (chk_pass) begin
      i_d = '0;
      j_d = '0;
      if (empty_rect) begin
        ok_d    = 1'b1;
        state_d = ST_DONE;
      end else begin
        state_d = ST_WRITE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      sweep_q    <= '0;
      pend_q     <= 1'b0;
      m_valid_q  <= 1'b0;
      cols_cfg_q <= ExtentBits'(64);
      rows_cfg_q <= ExtentBits'(64);
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COLUMNS: cols_cfg_q <= cfg_data_i;
          REG_ROWS:    rows_cfg_q <= cfg_data_i;
          default:     cols_cfg_q <= cols_cfg_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    base_x_q <= base_x_d;
    base_y_q <= base_y_d;
    old_x_q  <= old_x_d;
    old_y_q  <= old_y_d;
    w_q      <= w_d;
    h_q      <= h_d;
    i_q      <= i_d;
    j_q      <= j_d;
    id_q     <= id_d;
    rd_q     <= rd_d;
    ok_q     <= ok_d;
    out_ok_q <= out_ok_d;
    out_fx_q <= out_fx_d;
    out_fy_q <= out_fy_d;
    out_rd_q <= out_rd_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {3'b000, out_rd_q, out_fy_q, out_fx_q};

endmodule
